FILE: design/reoss_pkg.sv
// Shared types and constants for the rank error order statistic set.
package reoss_pkg;

    localparam int KEY_W  = 64;
    localparam int CNT_W  = 32;
    localparam int SUM_W  = 64;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [KEY_W-1:0] NEVER_POPPED = '1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;   // write an invalid entry at the sweep index
        logic load;    // capture the incoming word and clear the scan totals
        logic scan;    // read the store at the sweep index and advance
        logic rank;    // form the saturated rank from the scan totals
        logic finish;  // update store and statistics, load the output word
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_never;  // incoming key marks an element that is never popped
        logic idx_last;  // sweep index sits on the last store entry
        logic out_free;  // output register can take a new word this cycle
    } sts_t;

endpackage

FILE: design/rank_error_order_statistic_set.sv
// Top level of the rank error meter for a replayed push and pop event log.
//
// Input channel (in_valid, in_ready): one word per event, opcode and key.
// Output channel (out_valid, out_ready): one word per event with the rank of
// a counted push and the running maximum, sum, count and unmatched total.
// A key of all ones only bumps the unmatched total. It skips the store scan,
// and its word is loaded once the output register is free.
// Any other event scans the key store, a memory of CAPACITY entries read one
// entry per cycle, then passes through the last compare, the rank and the
// update. The block takes no new event until it has finished the last one.
// After reset the block sweeps the store, writing every entry invalid;
// in_ready is low during the sweep.
// Results sit in an output register; the next event is accepted and scanned
// while a word waits, and the block holds its finished result until
// out_ready frees the register.
module rank_error_order_statistic_set
#(
    parameter int CAPACITY = 256
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [reoss_pkg::KEY_W-1:0]   key,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [reoss_pkg::CNT_W-1:0]   rank,
    output logic                          rank_valid,
    output logic [reoss_pkg::CNT_W-1:0]   max_rank,
    output logic [reoss_pkg::SUM_W-1:0]   rank_total,
    output logic [reoss_pkg::CNT_W-1:0]   ranked_count,
    output logic [reoss_pkg::CNT_W-1:0]   unmatched_total,
    output logic                          store_full
);

    reoss_pkg::cmd_t cmd;
    reoss_pkg::sts_t sts;

    reoss_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    reoss_dpath
    #(
        .CAPACITY (CAPACITY)
    )
    u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .opcode          (opcode),
        .key             (key),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .rank            (rank),
        .rank_valid      (rank_valid),
        .max_rank        (max_rank),
        .rank_total      (rank_total),
        .ranked_count    (ranked_count),
        .unmatched_total (unmatched_total),
        .store_full      (store_full)
    );

endmodule

FILE: design/reoss_ctrl.sv
// Controller state machine: clearing pass, store scan and result sequencing.
module reoss_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  reoss_pkg::sts_t    sts,
    output reoss_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RANK,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.in_never ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RANK;
            end
            ST_RANK:
            begin
                cmd.rank   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/reoss_dpath.sv
// Datapath: key store memory, scan compare, rank statistics and output register.
module reoss_dpath
#(
    parameter int CAPACITY = 256
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  reoss_pkg::cmd_t               cmd,
    output reoss_pkg::sts_t               sts,
    input  logic                          opcode,
    input  logic [reoss_pkg::KEY_W-1:0]   key,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [reoss_pkg::CNT_W-1:0]   rank,
    output logic                          rank_valid,
    output logic [reoss_pkg::CNT_W-1:0]   max_rank,
    output logic [reoss_pkg::SUM_W-1:0]   rank_total,
    output logic [reoss_pkg::CNT_W-1:0]   ranked_count,
    output logic [reoss_pkg::CNT_W-1:0]   unmatched_total,
    output logic                          store_full
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int BW    = $clog2(CAPACITY + 1);
    localparam int KW    = reoss_pkg::KEY_W;
    localparam int CW    = reoss_pkg::CNT_W;
    localparam int SW    = reoss_pkg::SUM_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

    // Each entry holds its valid bit above the key.
    logic [KW:0]    mem [CAPACITY];

    logic [AW-1:0]  idx_reg;
    logic [AW-1:0]  rd_idx_reg;
    logic           rd_live_reg;
    logic [KW:0]    rd_data_reg;

    logic           op_reg;
    logic [KW-1:0]  key_reg;

    logic [BW-1:0]  below_reg;
    logic           present_reg;
    logic [AW-1:0]  hit_idx_reg;
    logic           free_found_reg;
    logic [AW-1:0]  free_idx_reg;
    logic [CW-1:0]  rank_reg;

    logic [CW-1:0]  unmatched_reg;
    logic [CW-1:0]  max_reg;
    logic [SW-1:0]  sum_reg;
    logic [CW-1:0]  count_reg;

    logic           out_valid_reg;
    logic [CW-1:0]  out_rank_reg;
    logic           out_rank_valid_reg;
    logic           out_full_reg;

    logic           item_never;
    logic           item_push;
    logic           item_pop;
    logic [CW:0]    rank_wide;
    logic [SW:0]    sum_wide;
    logic [CW-1:0]  unmatched_next;
    logic [CW-1:0]  max_next;
    logic [SW-1:0]  sum_next;
    logic [CW-1:0]  count_next;
    logic           full_next;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [KW:0]    wr_data;

    assign sts.in_never = (key == reoss_pkg::NEVER_POPPED);
    assign sts.idx_last = (idx_reg == LAST_IDX);
    assign sts.out_free = !out_valid_reg || out_ready;

    assign item_never = (key_reg == reoss_pkg::NEVER_POPPED);
    assign item_push  = !item_never && (op_reg == reoss_pkg::OP_PUSH);
    assign item_pop   = !item_never && (op_reg == reoss_pkg::OP_POP);

    assign rank_wide = (CW+1)'(unmatched_reg) + (CW+1)'(below_reg);
    assign sum_wide  = (SW+1)'(sum_reg) + (SW+1)'(rank_reg);

    always_comb
    begin
        unmatched_next = unmatched_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        full_next      = 1'b0;
        if (item_never)
        begin
            unmatched_next = (&unmatched_reg) ? unmatched_reg : unmatched_reg + 1'b1;
        end
        if (item_push)
        begin
            max_next   = (rank_reg > max_reg) ? rank_reg : max_reg;
            sum_next   = sum_wide[SW] ? '1 : sum_wide[SW-1:0];
            count_next = (&count_reg) ? count_reg : count_reg + 1'b1;
            full_next  = !present_reg && !free_found_reg;
        end
    end

    // One write port: the clearing sweep, an insert into a free slot or an erase.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = {1'b0, key_reg};
        if (cmd.clear)
        begin
            wr_en   = 1'b1;
            wr_data = '0;
        end
        else if (cmd.finish && item_push && !present_reg && free_found_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = free_idx_reg;
            wr_data = {1'b1, key_reg};
        end
        else if (cmd.finish && item_pop && present_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = hit_idx_reg;
            wr_data = {1'b0, key_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.scan)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            key_reg <= key;
        end
        if (cmd.scan)
        begin
            rd_idx_reg <= idx_reg;
        end
        if (cmd.rank)
        begin
            rank_reg <= rank_wide[CW] ? '1 : rank_wide[CW-1:0];
        end
        if (cmd.finish)
        begin
            out_rank_reg       <= item_push ? rank_reg : '0;
            out_rank_valid_reg <= item_push;
            out_full_reg       <= full_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            rd_live_reg    <= 1'b0;
            below_reg      <= '0;
            present_reg    <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            unmatched_reg  <= '0;
            max_reg        <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_live_reg <= cmd.scan;

            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.clear || cmd.scan)
            begin
                idx_reg <= sts.idx_last ? '0 : idx_reg + 1'b1;
            end

            if (cmd.load)
            begin
                below_reg      <= '0;
                present_reg    <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (rd_live_reg)
            begin
                if (rd_data_reg[KW])
                begin
                    if (rd_data_reg[KW-1:0] < key_reg)
                    begin
                        below_reg <= below_reg + 1'b1;
                    end
                    else if (rd_data_reg[KW-1:0] == key_reg)
                    begin
                        present_reg <= 1'b1;
                        hit_idx_reg <= rd_idx_reg;
                    end
                end
                else if (!free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= rd_idx_reg;
                end
            end

            if (cmd.finish)
            begin
                unmatched_reg <= unmatched_next;
                max_reg       <= max_next;
                sum_reg       <= sum_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign rank            = out_rank_reg;
    assign rank_valid      = out_rank_valid_reg;
    assign store_full      = out_full_reg;
    assign max_rank        = max_reg;
    assign rank_total      = sum_reg;
    assign ranked_count    = count_reg;
    assign unmatched_total = unmatched_reg;

endmodule

FILE: dv/rank_meter_checker.sv
// Checker that predicts and compares every result word of the rank error meter.
`timescale 1ns / 1ps

module rank_meter_checker
#(
    parameter int CAPACITY = 256
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          opcode,
    input  logic [reoss_pkg::KEY_W-1:0]   key,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [reoss_pkg::CNT_W-1:0]   rank,
    input  logic                          rank_valid,
    input  logic [reoss_pkg::CNT_W-1:0]   max_rank,
    input  logic [reoss_pkg::SUM_W-1:0]   rank_total,
    input  logic [reoss_pkg::CNT_W-1:0]   ranked_count,
    input  logic [reoss_pkg::CNT_W-1:0]   unmatched_total,
    input  logic                          store_full,
    output int                            mismatch_count,
    output int                            words_pending
);
    localparam int KEY_W = reoss_pkg::KEY_W;
    localparam int CNT_W = reoss_pkg::CNT_W;
    localparam int SUM_W = reoss_pkg::SUM_W;

    typedef struct packed {
        logic [CNT_W-1:0] rank;
        logic             rank_valid;
        logic [CNT_W-1:0] max_rank;
        logic [SUM_W-1:0] rank_total;
        logic [CNT_W-1:0] ranked_count;
        logic [CNT_W-1:0] unmatched_total;
        logic             store_full;
    } meter_word_t;

    logic [KEY_W-1:0] held_keys [CAPACITY];
    bit               slot_used [CAPACITY];
    logic [CNT_W-1:0] unmatched_cnt;
    logic [CNT_W-1:0] rank_peak;
    logic [SUM_W-1:0] sum_shadow;
    logic [CNT_W-1:0] rank_cnt;

    meter_word_t pending_words[$];
    meter_word_t seen_word;
    meter_word_t want_word;

    initial begin
        mismatch_count = 0;
        words_pending  = 0;
    end

    // Applies one event to the shadow set and statistics and returns its word.
    function automatic meter_word_t meter_event(logic op, logic [KEY_W-1:0] k);
        meter_word_t      w;
        logic [63:0]      below;
        logic [63:0]      sum_rank;
        logic             present;
        int               free_slot;
        w = '0;
        if (k == reoss_pkg::NEVER_POPPED) begin
            unmatched_cnt = (unmatched_cnt == '1) ? unmatched_cnt : unmatched_cnt + 1'b1;
        end
        else if (op == reoss_pkg::OP_PUSH) begin
            below     = '0;
            present   = 1'b0;
            free_slot = -1;
            for (int i = 0; i < CAPACITY; i++) begin
                if (slot_used[i]) begin
                    if (held_keys[i] < k)
                        below++;
                    else if (held_keys[i] == k)
                        present = 1'b1;
                end
                else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            sum_rank     = below + 64'(unmatched_cnt);
            w.rank       = (sum_rank > 64'hFFFF_FFFF) ? '1 : sum_rank[CNT_W-1:0];
            w.rank_valid = 1'b1;
            if (sum_shadow > ('1 - SUM_W'(w.rank)))
                sum_shadow = '1;
            else
                sum_shadow = sum_shadow + SUM_W'(w.rank);
            rank_cnt = (rank_cnt == '1) ? rank_cnt : rank_cnt + 1'b1;
            if (w.rank > rank_peak)
                rank_peak = w.rank;
            if (!present) begin
                if (free_slot >= 0) begin
                    held_keys[free_slot] = k;
                    slot_used[free_slot] = 1'b1;
                end
                else begin
                    w.store_full = 1'b1;
                end
            end
        end
        else begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (slot_used[i] && held_keys[i] == k) begin
                    slot_used[i] = 1'b0;
                    break;
                end
            end
        end
        w.max_rank        = rank_peak;
        w.rank_total      = sum_shadow;
        w.ranked_count    = rank_cnt;
        w.unmatched_total = unmatched_cnt;
        return w;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            for (int i = 0; i < CAPACITY; i++)
                slot_used[i] = 1'b0;
            unmatched_cnt = '0;
            rank_peak     = '0;
            sum_shadow    = '0;
            rank_cnt      = '0;
            pending_words.delete();
        end
        else begin
            // Compare first: a word leaving at this edge always belongs to an older event.
            if (out_valid && out_ready) begin
                seen_word = '{rank, rank_valid, max_rank, rank_total, ranked_count,
                              unmatched_total, store_full};
                if (pending_words.size() == 0) begin
                    report_mismatch("unexpected word", 64'd1, 64'd0);
                end
                else begin
                    want_word = pending_words.pop_front();
                    if (seen_word.rank !== want_word.rank)
                        report_mismatch("rank", 64'(seen_word.rank), 64'(want_word.rank));
                    if (seen_word.rank_valid !== want_word.rank_valid)
                        report_mismatch("rank_valid", 64'(seen_word.rank_valid),
                                        64'(want_word.rank_valid));
                    if (seen_word.max_rank !== want_word.max_rank)
                        report_mismatch("max_rank", 64'(seen_word.max_rank),
                                        64'(want_word.max_rank));
                    if (seen_word.rank_total !== want_word.rank_total)
                        report_mismatch("rank_total", seen_word.rank_total,
                                        want_word.rank_total);
                    if (seen_word.ranked_count !== want_word.ranked_count)
                        report_mismatch("ranked_count", 64'(seen_word.ranked_count),
                                        64'(want_word.ranked_count));
                    if (seen_word.unmatched_total !== want_word.unmatched_total)
                        report_mismatch("unmatched_total", 64'(seen_word.unmatched_total),
                                        64'(want_word.unmatched_total));
                    if (seen_word.store_full !== want_word.store_full)
                        report_mismatch("store_full", 64'(seen_word.store_full),
                                        64'(want_word.store_full));
                end
            end
            if (in_valid && in_ready)
                pending_words.insert(pending_words.size(), meter_event(opcode, key));
        end
        words_pending <= pending_words.size();
    end

endmodule

FILE: dv/tb.sv
// Testbench top: drives event words into the rank error meter and gives the verdict.
`timescale 1ns / 1ps

module tb;
    localparam int KEY_W       = reoss_pkg::KEY_W;
    localparam int CNT_W       = reoss_pkg::CNT_W;
    localparam int SUM_W       = reoss_pkg::SUM_W;
    localparam int CAPACITY    = 256;
    localparam int STALL_LIMIT = 20 * (CAPACITY + 5);
    localparam int ITEM_TARGET = 1600;
    localparam int CALM_AFTER  = 1400;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 opcode;
    logic [KEY_W-1:0]     key;
    logic                 out_valid;
    logic                 out_ready;
    logic [CNT_W-1:0]     rank;
    logic                 rank_valid;
    logic [CNT_W-1:0]     max_rank;
    logic [SUM_W-1:0]     rank_total;
    logic [CNT_W-1:0]     ranked_count;
    logic [CNT_W-1:0]     unmatched_total;
    logic                 store_full;
    int                   mismatch_count;
    int                   words_pending;

    int                   sent_count;
    int                   stall_cycles;
    bit                   calm;
    logic [KEY_W-1:0]     live_keys[$];

    always #1 clk = ~clk;

    rank_error_order_statistic_set #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .key             (key),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .rank            (rank),
        .rank_valid      (rank_valid),
        .max_rank        (max_rank),
        .rank_total      (rank_total),
        .ranked_count    (ranked_count),
        .unmatched_total (unmatched_total),
        .store_full      (store_full)
    );

    rank_meter_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .key             (key),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .rank            (rank),
        .rank_valid      (rank_valid),
        .max_rank        (max_rank),
        .rank_total      (rank_total),
        .ranked_count    (ranked_count),
        .unmatched_total (unmatched_total),
        .store_full      (store_full),
        .mismatch_count  (mismatch_count),
        .words_pending   (words_pending)
    );

    // A stall counts only cycles in which neither channel moves a word.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL rank_error_order_statistic_set");
            $finish;
        end
        else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Receiver back-pressure in random bursts, switched off for the last part.
    initial begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge clk);
            end
            else begin
                out_ready = 1'b1;
            end
        end
    end

    task automatic send_word(input logic op, input logic [KEY_W-1:0] k);
        @(negedge clk);
        calm = (sent_count >= CALM_AFTER);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid = 1'b1;
        opcode   = op;
        key      = k;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_count++;
    endtask

    task automatic push_key(input logic [KEY_W-1:0] k);
        send_word(reoss_pkg::OP_PUSH, k);
        if (k != reoss_pkg::NEVER_POPPED)
            live_keys.insert(live_keys.size(), k);
    endtask

    task automatic pop_live();
        int idx;
        logic [KEY_W-1:0] k;
        idx = $urandom_range(0, live_keys.size() - 1);
        k   = live_keys[idx];
        live_keys.delete(idx);
        send_word(reoss_pkg::OP_POP, k);
    endtask

    // Keys cluster in a small pool so duplicates, matched pops and ranks all show up.
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0:          k = reoss_pkg::NEVER_POPPED;
            1, 2, 3, 4: k = KEY_W'($urandom_range(0, 47));
            5:          k = {$urandom(), $urandom()};
            6:          k = reoss_pkg::NEVER_POPPED - KEY_W'($urandom_range(1, 8));
            7:          k = (KEY_W'($urandom_range(0, 15)) << 60) |
                            KEY_W'($urandom_range(0, 47));
            default:    k = (live_keys.size() > 0) ?
                            live_keys[$urandom_range(0, live_keys.size() - 1)] : '0;
        endcase
        return k;
    endfunction

    task automatic mix_events(input int n);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    if (live_keys.size() > 0)
                        pop_live();
                    else
                        push_key(pick_key());
                end
                3:       send_word(reoss_pkg::OP_POP, pick_key());
                default: push_key(pick_key());
            endcase
        end
    endtask

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = reoss_pkg::OP_PUSH;
        key          = '0;
        calm         = 1'b0;
        sent_count   = 0;
        stall_cycles = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed: key extremes, never-popped words both ways, duplicates, absent pops.
        send_word(reoss_pkg::OP_PUSH, '0);
        send_word(reoss_pkg::OP_PUSH, reoss_pkg::NEVER_POPPED - 1'b1);
        send_word(reoss_pkg::OP_PUSH, reoss_pkg::NEVER_POPPED);
        send_word(reoss_pkg::OP_POP,  reoss_pkg::NEVER_POPPED);
        send_word(reoss_pkg::OP_PUSH, 64'd5);
        send_word(reoss_pkg::OP_PUSH, 64'd5);
        send_word(reoss_pkg::OP_PUSH, 64'd3);
        send_word(reoss_pkg::OP_PUSH, 64'h5555_5555_5555_5555);
        send_word(reoss_pkg::OP_PUSH, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(reoss_pkg::OP_PUSH, 64'h8000_0000_0000_0000);
        send_word(reoss_pkg::OP_POP,  64'd1234);
        send_word(reoss_pkg::OP_POP,  64'd5);
        send_word(reoss_pkg::OP_POP,  64'd5);
        send_word(reoss_pkg::OP_PUSH, 64'd5);
        send_word(reoss_pkg::OP_POP,  '0);
        send_word(reoss_pkg::OP_POP,  reoss_pkg::NEVER_POPPED - 1'b1);
        send_word(reoss_pkg::OP_POP,  64'd3);
        send_word(reoss_pkg::OP_POP,  64'h5555_5555_5555_5555);
        send_word(reoss_pkg::OP_POP,  64'hAAAA_AAAA_AAAA_AAAA);
        send_word(reoss_pkg::OP_POP,  64'h8000_0000_0000_0000);
        send_word(reoss_pkg::OP_POP,  64'd5);
        push_key(64'd1);

        // Random: general traffic, then fill past capacity, work while full, drain, then more traffic up to the target.
        mix_events(350);
        repeat (CAPACITY + 12) push_key({$urandom(), $urandom()});
        mix_events(40);
        while (live_keys.size() > 0) pop_live();
        while (sent_count < ITEM_TARGET) mix_events(1);

        @(negedge clk);
        in_valid = 1'b0;
        while (words_pending != 0) @(posedge clk);
        repeat (CAPACITY + 10) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS rank_error_order_statistic_set");
        else
            $display("FAIL rank_error_order_statistic_set");
        $finish;
    end

endmodule
